// ----- rtl/core/touch_gesture_classifier_assert.svh -----
// Assertion macros used by the touch gesture classifier checker
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled while rst_n is low
`define TGC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgc assertion failed");

// Next-cycle implication, clocked on clk, disabled while rst_n is low
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgc assertion failed");

`endif

// ----- rtl/core/tgc_pkg.sv -----
// Types and constants of the touch gesture classifier
`default_nettype none
package tgc_pkg;

  // Event decode codes
  localparam logic [4:0]  TYPE_KEY      = 5'd1;
  localparam logic [4:0]  TYPE_ABS      = 5'd3;
  localparam logic [9:0]  CODE_X        = 10'd0;
  localparam logic [9:0]  CODE_Y        = 10'd1;
  localparam logic [9:0]  CODE_PRESSURE = 10'd24;
  localparam logic [9:0]  CODE_TOUCH    = 10'd330;

  // Threshold after reset
  localparam logic [9:0]  THR_RESET     = 10'd50;

  // x = floor(v*25/32); y = floor(4v/5) = (4v * 52429) >> 18, exact for 4v < 16384
  localparam logic [16:0] X_MUL         = 17'd25;
  localparam logic [15:0] Y_RECIP       = 16'd52429;

  typedef enum logic [2:0] {
    GEST_TAP   = 3'd0,
    GEST_UP    = 3'd1,
    GEST_DOWN  = 3'd2,
    GEST_LEFT  = 3'd3,
    GEST_RIGHT = 3'd4,
    GEST_TIE   = 3'd5
  } gesture_e;

  typedef enum logic [1:0] {
    OP_X,
    OP_Y,
    OP_RELEASE
  } op_kind_e;

  // Raw touch event
  typedef struct packed {
    logic [4:0]  event_type;
    logic [9:0]  event_code;
    logic [11:0] event_value;
  } event_t;

  // Classified gesture
  typedef struct packed {
    logic [2:0]  gesture;
    logic [11:0] release_x;
    logic [11:0] release_y;
  } result_t;

  // Decoded operation from front to back
  typedef struct packed {
    op_kind_e    kind;
    logic [11:0] pos;
  } op_t;

endpackage
`default_nettype wire

// ----- rtl/core/tgc_fifo.sv -----
// Small register-based queue used between the stages and on the result side
`default_nettype none
module tgc_fifo #(
  parameter int Depth = 2,
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and count update with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tgc_front.sv -----
// Front stage: takes raw events, decodes and scales them into operations
`default_nettype none
module tgc_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  tgc_pkg::event_t     item_i,
  output logic                full_o,
  output logic                op_push_o,
  output tgc_pkg::op_t        op_o,
  input  wire logic           op_full_i
);
  import tgc_pkg::*;

  logic        valid_q, valid_d;
  op_t         op_q, op_d;
  logic        accept;
  logic        is_x, is_y, is_rel, relevant;
  logic [16:0] x_prod;
  logic [29:0] y_prod;

  // Stage is free when empty or draining into the queue this cycle
  assign full_o    = valid_q && op_full_i;
  assign accept    = push_i && !full_o;
  assign op_push_o = valid_q;
  assign op_o      = op_q;

  // Decode the event
  always_comb begin
    is_x   = (item_i.event_type == TYPE_ABS) && (item_i.event_code == CODE_X);
    is_y   = (item_i.event_type == TYPE_ABS) && (item_i.event_code == CODE_Y);
    is_rel = (item_i.event_value == '0) &&
             (((item_i.event_type == TYPE_KEY) && (item_i.event_code == CODE_TOUCH)) ||
              ((item_i.event_type == TYPE_ABS) && (item_i.event_code == CODE_PRESSURE)));
    relevant = is_x || is_y || is_rel;
  end

  // Constant scaling to pixels
  always_comb begin
    x_prod = {5'b0, item_i.event_value} * X_MUL;
    y_prod = {2'b0, item_i.event_value, 2'b00} * {14'b0, Y_RECIP};
  end

  // Build the operation and the stage valid
  always_comb begin
    op_d    = op_q;
    valid_d = valid_q && op_full_i;
    if (accept) begin
      valid_d = relevant;
      if (is_x) begin
        op_d.kind = OP_X;
        op_d.pos  = x_prod[16:5];
      end else if (is_y) begin
        op_d.kind = OP_Y;
        op_d.pos  = y_prod[29:18];
      end else begin
        op_d.kind = OP_RELEASE;
        op_d.pos  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

endmodule
`default_nettype wire

// ----- rtl/core/tgc_back.sv -----
// Back stage: keeps the touch points and classifies the gesture on release
`default_nettype none
module tgc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  tgc_pkg::op_t        op_i,
  input  wire logic           op_empty_i,
  output logic                op_pop_o,
  input  wire logic [9:0]     thr_i,
  output logic                res_push_o,
  output tgc_pkg::result_t    res_o,
  input  wire logic           res_full_i
);
  import tgc_pkg::*;

  logic [11:0] sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  logic        sxv_q, sxv_d, syv_q, syv_d, exv_q, exv_d, eyv_q, eyv_d;
  logic        all_valid, is_rel, consume;
  logic        x_neg, y_neg;
  logic [11:0] adx, ady;
  gesture_e    gest;

  assign all_valid = sxv_q && syv_q && exv_q && eyv_q;
  assign is_rel    = (op_i.kind == OP_RELEASE);
  // A release waits only when the result queue is full
  assign consume   = !op_empty_i && !(is_rel && res_full_i);
  assign op_pop_o  = consume;
  assign res_push_o = consume && is_rel && all_valid;

  // Deltas and classification
  always_comb begin
    x_neg = (ex_q < sx_q);
    y_neg = (ey_q < sy_q);
    adx   = x_neg ? (sx_q - ex_q) : (ex_q - sx_q);
    ady   = y_neg ? (sy_q - ey_q) : (ey_q - sy_q);
    if ((adx < {2'b0, thr_i}) && (ady < {2'b0, thr_i})) begin
      gest = GEST_TAP;
    end else if (adx < ady) begin
      gest = y_neg ? GEST_UP : GEST_DOWN;
    end else if (adx > ady) begin
      gest = x_neg ? GEST_LEFT : GEST_RIGHT;
    end else begin
      gest = GEST_TIE;
    end
    res_o.gesture   = gest;
    res_o.release_x = ex_q;
    res_o.release_y = ey_q;
  end

  // Point update
  always_comb begin
    sx_d = sx_q; sy_d = sy_q; ex_d = ex_q; ey_d = ey_q;
    sxv_d = sxv_q; syv_d = syv_q; exv_d = exv_q; eyv_d = eyv_q;
    if (consume) begin
      case (op_i.kind)
        OP_X: begin
          if (!sxv_q) begin
            sx_d  = op_i.pos;
            sxv_d = 1'b1;
          end
          ex_d  = op_i.pos;
          exv_d = 1'b1;
        end
        OP_Y: begin
          if (!syv_q) begin
            sy_d  = op_i.pos;
            syv_d = 1'b1;
          end
          ey_d  = op_i.pos;
          eyv_d = 1'b1;
        end
        OP_RELEASE: begin
          if (all_valid) begin
            sxv_d = 1'b0; syv_d = 1'b0; exv_d = 1'b0; eyv_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sxv_q <= 1'b0;
      syv_q <= 1'b0;
      exv_q <= 1'b0;
      eyv_q <= 1'b0;
    end else begin
      sxv_q <= sxv_d;
      syv_q <= syv_d;
      exv_q <= exv_d;
      eyv_q <= eyv_d;
    end
  end

  // Positions, meaningful only while valid
  always_ff @(posedge clk_i) begin
    sx_q <= sx_d;
    sy_q <= sy_d;
    ex_q <= ex_d;
    ey_q <= ey_d;
  end

endmodule
`default_nettype wire

// ----- rtl/core/touch_gesture_classifier.sv -----
// Touch gesture classifier: tap and swipe detection from raw touch events
// Throughput: one event per cycle on the input and one result per cycle on the output
//   while no queue is full. A release goes from the front register into the op queue,
//   then the back stage writes its result into the result queue.
// The op queue and result queue each hold FifoDepth items and decouple the stages.
// Reset (rst_ni low, asynchronous): queues empty, all touch points invalid, threshold 50.
`default_nettype none
module touch_gesture_classifier #(
  parameter int FifoDepth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  input  tgc_pkg::event_t     in_item_i,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output tgc_pkg::result_t    res_item_o,
  input  wire logic           cfg_we_i,
  input  wire logic [9:0]     cfg_wdata_i
);
  import tgc_pkg::*;

  logic [9:0]  thr_val_q;
  op_t         fr_op, bk_op;
  logic        fr_push, op_full, op_empty, op_pop;
  result_t     bk_res;
  logic        res_push, res_full;

  // Tap threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_val_q <= THR_RESET;
    end else begin
      if (cfg_we_i) begin
        thr_val_q <= cfg_wdata_i;
      end
    end
  end

  tgc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (in_item_i),
    .full_o    (full),
    .op_push_o (fr_push),
    .op_o      (fr_op),
    .op_full_i (op_full)
  );

  tgc_fifo #(
    .Depth (FifoDepth),
    .Width ($bits(op_t))
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_op),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .data_o  (bk_op),
    .empty_o (op_empty)
  );

  tgc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (bk_op),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .thr_i      (thr_val_q),
    .res_push_o (res_push),
    .res_o      (bk_res),
    .res_full_i (res_full)
  );

  tgc_fifo #(
    .Depth (FifoDepth),
    .Width ($bits(result_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (bk_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_item_o),
    .empty_o (empty)
  );

endmodule
`default_nettype wire

// ----- rtl/core/tgc_checker.sv -----
// Port-level checker for the touch gesture classifier, bound to the top level
`default_nettype none
`include "touch_gesture_classifier_assert.svh"
module tgc_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           full,
  input  wire logic           empty,
  input  wire logic           pop,
  input  tgc_pkg::result_t    res_item_o
);
  import tgc_pkg::*;

  // Coming out of reset nothing is waiting and the input is open
  `TGC_ASSERT_NOW(a_reset_idle, clk_i, rst_ni, $rose(rst_ni), empty && !full)

  // Only defined gesture codes are ever shown
  `TGC_ASSERT_NOW(a_gesture_code, clk_i, rst_ni, !empty, res_item_o.gesture <= GEST_TIE)

  // Release coordinates stay within the scaled screen range
  `TGC_ASSERT_NOW(a_coord_range, clk_i, rst_ni, !empty,
                  (res_item_o.release_x <= 12'd3199) && (res_item_o.release_y <= 12'd3276))

  // A result not taken stays in place
  `TGC_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, !empty && !pop,
                   !empty && $stable(res_item_o))

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (.*);
`default_nettype wire

// ----- bench/touch_gesture_classifier_checker.sv -----
// Gesture checker: tracks accepted touch events, predicts gestures, compares each result
module touch_gesture_classifier_checker
  import tgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  event_t      evt_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  result_t     res_i,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  output int          pending_o,
  output int          errors_o
);

  // Predicted touch state
  logic [9:0]  tap_thr;
  logic [11:0] first_x, first_y, last_x, last_y;
  logic        first_x_ok, first_y_ok, last_x_ok, last_y_ok;

  // Gestures predicted but not yet seen on the output
  result_t     expected_gestures[$];
  int          waiting;
  int          errors;

  assign pending_o = waiting;
  assign errors_o  = errors;

  // x = floor(v * 25 / 32)
  function automatic logic [11:0] screen_x(input logic [11:0] raw);
    logic [16:0] prod;
    prod = {5'd0, raw} * 17'd25;
    return prod[16:5];
  endfunction

  // y = floor(v * 4 / 5)
  function automatic logic [11:0] screen_y(input logic [11:0] raw);
    logic [13:0] quad;
    quad = {raw, 2'b00};
    return 12'(quad / 14'd5);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic clear_touch();
    first_x    = '0;
    first_y    = '0;
    last_x     = '0;
    last_y     = '0;
    first_x_ok = 1'b0;
    first_y_ok = 1'b0;
    last_x_ok  = 1'b0;
    last_y_ok  = 1'b0;
  endtask

  // Update touch state for one event; a complete release predicts a gesture
  task automatic track_event(input event_t ev);
    logic [11:0] pos, adx, ady;
    logic        is_release;
    gesture_e    gest;
    result_t     want;
    is_release = ((ev.event_type == TYPE_KEY) && (ev.event_code == CODE_TOUCH) ||
                  (ev.event_type == TYPE_ABS) && (ev.event_code == CODE_PRESSURE)) &&
                 (ev.event_value == 12'd0);
    if (ev.event_type == TYPE_ABS && ev.event_code == CODE_X) begin
      pos = screen_x(ev.event_value);
      if (!first_x_ok) begin
        first_x    = pos;
        first_x_ok = 1'b1;
      end
      last_x    = pos;
      last_x_ok = 1'b1;
    end else if (ev.event_type == TYPE_ABS && ev.event_code == CODE_Y) begin
      pos = screen_y(ev.event_value);
      if (!first_y_ok) begin
        first_y    = pos;
        first_y_ok = 1'b1;
      end
      last_y    = pos;
      last_y_ok = 1'b1;
    end else if (is_release && first_x_ok && first_y_ok && last_x_ok && last_y_ok) begin
      adx = (last_x > first_x) ? last_x - first_x : first_x - last_x;
      ady = (last_y > first_y) ? last_y - first_y : first_y - last_y;
      if (adx < {2'b00, tap_thr} && ady < {2'b00, tap_thr}) begin
        gest = GEST_TAP;
      end else if (adx < ady) begin
        gest = (last_y < first_y) ? GEST_UP : GEST_DOWN;
      end else if (adx > ady) begin
        gest = (last_x < first_x) ? GEST_LEFT : GEST_RIGHT;
      end else begin
        gest = GEST_TIE;
      end
      want.gesture   = gest;
      want.release_x = last_x;
      want.release_y = last_y;
      expected_gestures.push_back(want);
      clear_touch();
    end
  endtask

  // Compare one popped result with the oldest prediction
  task automatic check_gesture(input result_t got);
    result_t want;
    if (expected_gestures.size() == 0) begin
      report_mismatch($sformatf("unexpected result gesture %0d x %0d y %0d",
                                got.gesture, got.release_x, got.release_y));
    end else begin
      want = expected_gestures.pop_front();
      if (got.gesture !== want.gesture)
        report_mismatch($sformatf("gesture got %0d want %0d", got.gesture, want.gesture));
      if (got.release_x !== want.release_x)
        report_mismatch($sformatf("release_x got %0d want %0d",
                                  got.release_x, want.release_x));
      if (got.release_y !== want.release_y)
        report_mismatch($sformatf("release_y got %0d want %0d",
                                  got.release_y, want.release_y));
    end
  endtask

  // Sample both channels and the register port at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_thr = THR_RESET;
      clear_touch();
      expected_gestures.delete();
      waiting = 0;
    end else begin
      if (pop_i && !empty_i) check_gesture(res_i);
      if (cfg_we_i) tap_thr = cfg_wdata_i;
      if (push_i && !full_i) track_event(evt_i);
      waiting = expected_gestures.size();
    end
  end

  initial errors = 0;

endmodule

// ----- bench/touch_gesture_classifier_test.sv -----
// Testbench top: drives touch events and threshold writes, reports the verdict
module touch_gesture_classifier_test;
  import tgc_pkg::*;

  localparam int StallLimit  = 4000;
  localparam int TargetItems = 1050;
  localparam int NumPhases   = 7;

  logic       clk;
  logic       rst_n;
  logic       push;
  event_t     in_item;
  logic       full;
  logic       empty;
  logic       pop;
  result_t    res_item;
  logic       cfg_we;
  logic [9:0] cfg_wdata;

  int         pending;
  int         errors;
  int         live_items;
  int         stall_cycles;
  int         pop_hold;
  bit         quiet;

  touch_gesture_classifier u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .in_item_i   (in_item),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .res_item_o  (res_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  touch_gesture_classifier_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .evt_i       (in_item),
    .empty_i     (empty),
    .pop_i       (pop),
    .res_i       (res_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    pop       = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    pop_hold  = 0;
    live_items = 0;
    stall_cycles = 0;
  end

  always #6 clk = ~clk;

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic event_t mk_event(input logic [4:0] typ, input logic [9:0] code,
                                      input logic [11:0] val);
    event_t ev;
    ev.event_type  = typ;
    ev.event_code  = code;
    ev.event_value = val;
    return ev;
  endfunction

  function automatic int clamp_raw(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_event(input event_t ev, input bit live);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= ev;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (live) live_items++;
  endtask

  task automatic send_x(input int raw);
    send_event(mk_event(TYPE_ABS, CODE_X, 12'(raw)), 1'b1);
  endtask

  task automatic send_y(input int raw);
    send_event(mk_event(TYPE_ABS, CODE_Y, 12'(raw)), 1'b1);
  endtask

  task automatic send_release(input bit by_pressure);
    if (by_pressure) send_event(mk_event(TYPE_ABS, CODE_PRESSURE, 12'd0), 1'b1);
    else send_event(mk_event(TYPE_KEY, CODE_TOUCH, 12'd0), 1'b1);
  endtask

  // Extra events, mostly ones the block should ignore, near misses included
  task automatic send_noise();
    event_t ev;
    case ($urandom_range(0, 3))
      0: ev = mk_event(TYPE_ABS, CODE_PRESSURE, 12'($urandom_range(1, 4095)));
      1: ev = mk_event(TYPE_KEY, CODE_TOUCH, 12'($urandom_range(1, 4095)));
      2: ev = mk_event(TYPE_ABS, 10'($urandom_range(2, 767)), 12'($urandom));
      default: ev = mk_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                             12'($urandom));
    endcase
    send_event(ev, 1'b0);
  endtask

  // One touch: start point, some moves, end point, release; sometimes broken
  task automatic touch_seq();
    int  mode, sx, sy, ex, ey, m, a, b, t, moves;
    bit  broken, drop_x;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      // diagonal: raw steps of 128 and 125 give equal 100 px steps
      m  = $urandom_range(0, 15);
      a  = $urandom_range(0, 31 - m);
      b  = $urandom_range(0, 32 - m);
      sx = 128 * a;
      ex = 128 * (a + m);
      sy = 125 * b;
      ey = 125 * (b + m);
      if ($urandom_range(0, 1)) begin t = sx; sx = ex; ex = t; end
      if ($urandom_range(0, 1)) begin t = sy; sy = ey; ey = t; end
    end else if (mode < 6) begin
      // small moves around typical thresholds
      sx = $urandom_range(0, 4095);
      sy = $urandom_range(0, 4095);
      ex = clamp_raw(sx + $urandom_range(0, 160) - 80);
      ey = clamp_raw(sy + $urandom_range(0, 160) - 80);
    end else begin
      sx = $urandom_range(0, 4095);
      sy = $urandom_range(0, 4095);
      ex = $urandom_range(0, 4095);
      ey = $urandom_range(0, 4095);
    end
    broken = ($urandom_range(0, 9) == 0);
    drop_x = $urandom_range(0, 1);

    if ($urandom_range(0, 1)) begin
      if (!(broken && drop_x)) send_x(sx);
      if (!(broken && !drop_x)) send_y(sy);
    end else begin
      if (!(broken && !drop_x)) send_y(sy);
      if (!(broken && drop_x)) send_x(sx);
    end
    moves = $urandom_range(0, 3);
    repeat (moves) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      if ($urandom_range(0, 1)) begin
        if (!(broken && drop_x)) send_x($urandom_range(0, 4095));
      end else begin
        if (!(broken && !drop_x)) send_y($urandom_range(0, 4095));
      end
    end
    if (!(broken && drop_x)) send_x(ex);
    if (!(broken && !drop_x)) send_y(ey);
    if ($urandom_range(0, 7) == 0) send_noise();
    send_release($urandom_range(0, 1));
    // a second release finds no points
    if ($urandom_range(0, 9) == 0) send_release($urandom_range(0, 1));
  endtask

  // Threshold write once the block has drained
  task automatic write_threshold(input logic [9:0] thr);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= thr;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: pop with random stalls
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      pop_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("touch_gesture_classifier_test failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [9:0] thr;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, threshold at its reset value
    send_release(1'b0);                       // release with no points
    send_x(0); send_y(0); send_x(128); send_y(125);
    send_release(1'b1);                       // equal deltas: tie
    send_x(4095); send_y(4095);
    send_release(1'b0);                       // no move at max coordinates: tap
    send_x(1000);
    send_release(1'b1);                       // Y missing: nothing, points kept
    send_y(2000); send_x(4095);
    send_event(mk_event(TYPE_KEY, CODE_TOUCH, 12'd1), 1'b0);
    send_event(mk_event(5'd31, 10'd767, 12'hFFF), 1'b0);
    send_release(1'b0);                       // right
    send_x(4095); send_y(100); send_x(0);
    send_release(1'b1);                       // left
    send_y(4095); send_x(5); send_y(0);
    send_event(mk_event(TYPE_ABS, CODE_PRESSURE, 12'd1), 1'b0);
    send_release(1'b0);                       // up

    // Random phases, each with its own threshold
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: thr = 10'd0;
        1: thr = 10'd1023;
        2: thr = 10'd1;
        3: thr = 10'd512;
        6: thr = THR_RESET;
        default: thr = 10'($urandom_range(2, 1022));
      endcase
      write_threshold(thr);
      quiet = (p == 3);
      if (p == 0) begin
        // zero threshold, no movement: tie
        send_x(7); send_y(7);
        send_release(1'b0);
      end
      while (live_items < (TargetItems * (p + 1)) / NumPhases) touch_seq();
    end
    quiet = 1'b0;

    // Drain and settle
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("touch_gesture_classifier_test passed");
    end else begin
      $display("touch_gesture_classifier_test failed");
    end
    $finish;
  end

endmodule
